@@ sv/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, codes and helpers of the four-level page table engine.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // table store geometry
  localparam int TABLE_PAGES = 16;
  localparam int PG_W        = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int IDX_W       = 9;
  localparam int AW          = PG_W + IDX_W;
  localparam int DEPTH       = TABLE_PAGES * 512;
  localparam int NFP_W       = $clog2(TABLE_PAGES + 1);
  localparam int ENTRY_W     = 64;

  // request op codes
  localparam logic [2:0] OP_MAP4K   = 3'd0;
  localparam logic [2:0] OP_MAP2M   = 3'd1;
  localparam logic [2:0] OP_UNMAP4K = 3'd2;
  localparam logic [2:0] OP_UNMAP2M = 3'd3;
  localparam logic [2:0] OP_XLATE   = 3'd4;
  localparam logic [2:0] OP_FLAGS   = 3'd5;

  // response status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ALIGN    = 3'd1;
  localparam logic [2:0] ST_MAPPED   = 3'd2;
  localparam logic [2:0] ST_UNMAPPED = 3'd3;
  localparam logic [2:0] ST_NOPAGE   = 3'd4;

  // entry bit positions
  localparam int E_PRESENT = 0;
  localparam int E_HUGE    = 7;

  // result of following a table entry
  typedef struct packed {
    logic            ok;
    logic [PG_W-1:0] pg;
  } child_t;

  // 9-bit table index of a virtual address at walk level 0..3
  function automatic logic [IDX_W-1:0] idx_of(input logic [47:0] va, input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

@@ sv/ptw_req_if.sv @@
// ----------------------------------------------------------------------------
// ptw_req_if
// Request channel: op, virtual address, physical address and leaf flags.
// ----------------------------------------------------------------------------
interface ptw_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [47:0] virt_addr;
  logic [51:0] phys_addr;
  logic [11:0] leaf_flags;

  modport source (output valid, op, virt_addr, phys_addr, leaf_flags, input ready);
  modport sink   (input valid, op, virt_addr, phys_addr, leaf_flags, output ready);
endinterface

@@ sv/ptw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ptw_rsp_if
// Response channel: status, translated address, flags and invalidate.
// ----------------------------------------------------------------------------
interface ptw_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [51:0] phys_out;
  logic [11:0] flags_out;
  logic        invalidate;

  modport source (output valid, status, phys_out, flags_out, invalidate, input ready);
  modport sink   (input valid, status, phys_out, flags_out, invalidate, output ready);
endinterface

@@ sv/ptw_ram.sv @@
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int W = 64,
  parameter int D = 8192
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ sv/ptw_child.sv @@
// ----------------------------------------------------------------------------
// ptw_child
// Maps a table entry's address to a page of the store, or flags it unreachable.
// ----------------------------------------------------------------------------
module ptw_child import ptw_pkg::*; (
  input  logic [ENTRY_W-1:0] entry,
  input  logic [51:0]        root,
  output child_t             child
);
  logic [39:0] a;
  logic [39:0] r;
  logic [39:0] diff;

  // offset in pages from the store base
  always_comb begin
    a           = entry[51:12];
    r           = root[51:12];
    diff        = a - r;
    child.ok    = (a >= r) && (diff < 40'(TABLE_PAGES));
    child.pg    = diff[PG_W-1:0];
  end
endmodule

@@ sv/four_level_page_table_engine_unit.sv @@
// Throughput: one request at a time. A misaligned or unknown op goes straight to
// the response; otherwise each table level takes a read state and an evaluate state
// on the single store port, an entry write takes a write state, and each table
// allocated is first zero filled in a state of its own.
// Reset: a clearing pass over all TABLE_PAGES*512 entries (8192) zeroes the store;
// requests are not accepted until it ends.
// ----------------------------------------------------------------------------
// four_level_page_table_engine_unit
// Sequencer that walks, allocates and edits four-level page tables in one RAM.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_unit import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [51:0] cfg_wdata,
  ptw_req_if.sink     req,
  ptw_rsp_if.source   rsp
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_EV, S_ZERO, S_WR, S_OUT} state_t;

  state_t             state;
  logic [AW-1:0]      cnt;
  logic [2:0]         op_r;
  logic [47:0]        va_r;
  logic [51:0]        pa_r;
  logic [11:0]        fl_r;
  logic [1:0]         lvl;
  logic [PG_W-1:0]    cur_pg;
  logic [PG_W-1:0]    zpg;
  logic [ENTRY_W-1:0] wdata_r;
  logic               after_wr;
  logic [NFP_W-1:0]   nfp;
  logic [51:0]        root;
  logic [2:0]         status_r;
  logic [51:0]        phys_r;
  logic [11:0]        flags_r;
  logic               inv_r;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wd;
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0]      slot;
  logic [ENTRY_W-1:0] child_in;
  child_t             child;
  logic [ENTRY_W-1:0] e;
  logic [ENTRY_W-1:0] alloc_entry;
  logic               misalign;

  ptw_ram #(.W(ENTRY_W), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (rdata)
  );

  // shared entry-to-page unit, fed by read data or a freshly built entry
  assign child_in = (state == S_WR) ? wdata_r : rdata;

  ptw_child u_child (
    .entry (child_in),
    .root  (root),
    .child (child)
  );

  // current slot and store port control
  always_comb begin
    slot     = {cur_pg, idx_of(va_r, lvl)};
    ram_we   = 1'b0;
    ram_addr = slot;
    ram_wd   = wdata_r;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = cnt;
        ram_wd = '0;
      end
      S_ZERO: begin
        ram_we = 1'b1;
        ram_addr = {zpg, cnt[IDX_W-1:0]};
        ram_wd = '0;
      end
      S_WR: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  // entry for a new table page, alignment check of an incoming request
  always_comb begin
    e           = rdata;
    alloc_entry = {12'b0, root[51:12] + 40'(nfp), 12'h003};
    case (req.op)
      OP_MAP4K:   misalign = (req.virt_addr[11:0] != '0) || (req.phys_addr[11:0] != '0);
      OP_MAP2M:   misalign = (req.virt_addr[20:0] != '0) || (req.phys_addr[20:0] != '0);
      OP_UNMAP4K: misalign = (req.virt_addr[11:0] != '0);
      OP_UNMAP2M: misalign = (req.virt_addr[20:0] != '0);
      default:    misalign = 1'b0;
    endcase
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = (state == S_OUT);
  assign rsp.status     = status_r;
  assign rsp.phys_out   = phys_r;
  assign rsp.flags_out  = flags_r;
  assign rsp.invalidate = inv_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_we) begin
      root <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      nfp   <= NFP_W'(1);
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            op_r     <= req.op;
            va_r     <= req.virt_addr;
            pa_r     <= req.phys_addr;
            fl_r     <= req.leaf_flags;
            lvl      <= 2'd0;
            cur_pg   <= '0;
            status_r <= ST_OK;
            phys_r   <= '0;
            flags_r  <= '0;
            inv_r    <= 1'b0;
            if (req.op > OP_FLAGS) begin
              state <= S_OUT;
            end else if (misalign) begin
              status_r <= ST_ALIGN;
              state    <= S_OUT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          state    <= S_OUT;
          after_wr <= 1'b0;
          if (lvl != 2'd3 && !(lvl == 2'd2 && op_r != OP_MAP4K) &&
              (op_r == OP_MAP4K || op_r == OP_MAP2M) &&
              !(lvl == 2'd2 && e[E_PRESENT] && e[E_HUGE])) begin
            // table needed below this level of a map
            if (e[E_PRESENT]) begin
              if (child.ok) begin
                cur_pg <= child.pg;
                lvl    <= lvl + 1'b1;
                state  <= S_RD;
              end else begin
                status_r <= ST_NOPAGE;
              end
            end else if (nfp >= NFP_W'(TABLE_PAGES)) begin
              status_r <= ST_NOPAGE;
            end else begin
              wdata_r  <= alloc_entry;
              zpg      <= nfp[PG_W-1:0];
              nfp      <= nfp + 1'b1;
              cnt      <= '0;
              after_wr <= 1'b1;
              state    <= S_ZERO;
            end
          end else if (lvl < 2'd2) begin
            // walk through upper levels
            if (e[E_PRESENT] && child.ok) begin
              cur_pg <= child.pg;
              lvl    <= lvl + 1'b1;
              state  <= S_RD;
            end else begin
              status_r <= ST_UNMAPPED;
            end
          end else if (lvl == 2'd2) begin
            case (op_r)
              OP_MAP2M: begin
                if (e[E_PRESENT]) begin
                  status_r <= ST_MAPPED;
                end else begin
                  wdata_r <= {12'b0, pa_r} | {52'b0, (fl_r & ~12'h081) | 12'h081};
                  inv_r   <= 1'b1;
                  state   <= S_WR;
                end
              end
              OP_MAP4K: status_r <= ST_MAPPED;
              OP_UNMAP2M: begin
                if (e[E_PRESENT]) begin
                  wdata_r <= '0;
                  inv_r   <= 1'b1;
                  state   <= S_WR;
                end else begin
                  status_r <= ST_UNMAPPED;
                end
              end
              default: begin
                if (!e[E_PRESENT]) begin
                  status_r <= ST_UNMAPPED;
                end else if (e[E_HUGE]) begin
                  case (op_r)
                    OP_UNMAP4K: begin
                      wdata_r <= '0;
                      inv_r   <= 1'b1;
                      state   <= S_WR;
                    end
                    OP_XLATE: phys_r  <= {e[51:21], va_r[20:0]};
                    default:  flags_r <= e[11:0];
                  endcase
                end else if (!child.ok) begin
                  status_r <= ST_UNMAPPED;
                end else begin
                  cur_pg <= child.pg;
                  lvl    <= 2'd3;
                  state  <= S_RD;
                end
              end
            endcase
          end else begin
            // last level entry
            case (op_r)
              OP_MAP4K: begin
                if (e[E_PRESENT]) begin
                  status_r <= ST_MAPPED;
                end else begin
                  wdata_r <= {12'b0, pa_r} | {52'b0, (fl_r & ~12'h001) | 12'h001};
                  inv_r   <= 1'b1;
                  state   <= S_WR;
                end
              end
              OP_UNMAP4K: begin
                if (e[E_PRESENT]) begin
                  wdata_r <= '0;
                  inv_r   <= 1'b1;
                  state   <= S_WR;
                end else begin
                  status_r <= ST_UNMAPPED;
                end
              end
              OP_XLATE: begin
                if (e[E_PRESENT]) phys_r <= {e[51:12], va_r[11:0]};
                else status_r <= ST_UNMAPPED;
              end
              default: flags_r <= e[11:0];
            endcase
          end
        end
        S_ZERO: begin
          cnt <= cnt + 1'b1;
          if (cnt[IDX_W-1:0] == '1) state <= S_WR;
        end
        S_WR: begin
          state <= S_OUT;
          if (after_wr) begin
            if (child.ok) begin
              cur_pg <= child.pg;
              lvl    <= lvl + 1'b1;
              state  <= S_RD;
            end else begin
              status_r <= ST_NOPAGE;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
